>>> hdl/ccwt_pkg.sv
// Package: shared types, constants and date helpers of the weekly timer clock
package ccwt_pkg;

	localparam int SLOTS_PER_DAY_DEF = 8;
	localparam int DAYS_PER_WEEK = 7;
	localparam int RESULT_LIMIT = 8;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_SET = 2'd1;
	localparam logic [1:0] CMD_SLOT = 2'd2;

	localparam logic [2:0] SEL_SEC = 3'd0;
	localparam logic [2:0] SEL_MIN = 3'd1;
	localparam logic [2:0] SEL_HOUR = 3'd2;
	localparam logic [2:0] SEL_DAY = 3'd3;
	localparam logic [2:0] SEL_MONTH = 3'd4;
	localparam logic [2:0] SEL_YEAR = 3'd5;

	typedef struct packed {
		logic [1:0] cmd;
		logic [2:0] field_select;
		logic [7:0] set_value;
		logic [2:0] slot_weekday;
		logic [2:0] slot_index;
		logic [7:0] slot_time;
	} in_item_t;

	typedef struct packed {
		logic [5:0] second_now;
		logic [5:0] minute_now;
		logic [4:0] hour_now;
		logic [4:0] day_now;
		logic [3:0] month_now;
		logic [7:0] year_now;
		logic [2:0] weekday_now;
		logic       dst_done_now;
		logic       event_valid;
		logic [2:0] event_slot;
		logic       last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WDAY,
		ST_SCAN,
		ST_EMIT,
		ST_DONE
	} state_t;

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic [7:0] y);
		logic [4:0] d;
		begin
			case (m)
				4'd2: d = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
				4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
				default: d = 5'd31;
			endcase
			return d;
		end
	endfunction

	// Day-of-year offset before month m (31*(m-1) minus corrections)
	function automatic logic [8:0] month_base(input logic [3:0] m, input logic leap);
		logic [8:0] b;
		begin
			b = 9'(31 * ({5'd0, m} - 9'd1));
			if (m > 4'd2) b = b - (leap ? 9'd2 : 9'd3);
			if (m > 4'd4) b = b - 9'd1;
			if (m > 4'd6) b = b - 9'd1;
			if (m > 4'd9) b = b - 9'd1;
			if (m > 4'd11) b = b - 9'd1;
			return b;
		end
	endfunction

endpackage

>>> hdl/calendar_clock_weekly_timer_top.sv
// Top level: calendar clock with daylight saving and weekly timer table
//
// Usage: one input channel (in, in_valid, in_stall) carries transactions of
// three kinds: a one-second tick, a set of one clock field and a write of one
// timer slot. One output channel (out, out_valid, out_stall) carries one to
// eight result transactions per input, the final one marked by last.
// Every result carries the clock state after the input.
// A plain input passes through ST_DONE, which registers its result and raises
// out_valid; a day, month or year set first reduces the weekday residue in
// ST_WDAY, one subtract a cycle. A tick that lands on a ten-minute boundary
// scans today's slots one per cycle through the slot RAM port, pausing while
// each earlier event waits in ST_EMIT to be taken, then sends its final result.
// Only one input is in flight; in_stall stays high until its last result has
// been taken. A stalled receiver holds out steady and blocks the block.
// Reset: the clock returns to 00:00:00, 1 January 2008, Tuesday. The slot RAM
// is swept to 255 after reset, one entry a cycle, with in_stall high meanwhile.
module calendar_clock_weekly_timer_top #(
	parameter int SLOTS_PER_DAY = ccwt_pkg::SLOTS_PER_DAY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ccwt_pkg::in_item_t  in,
	input  logic                in_valid,
	output logic                in_stall,
	output ccwt_pkg::out_item_t out,
	output logic                out_valid,
	input  logic                out_stall
);
	localparam int DEPTH = ccwt_pkg::DAYS_PER_WEEK * SLOTS_PER_DAY;
	localparam int AW = $clog2(DEPTH);
	localparam int SW = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;
	localparam int CW = $clog2(SLOTS_PER_DAY + 1);

	ccwt_pkg::state_t state_q, state_d;

	logic [5:0] sec_q, min_q;
	logic [4:0] hour_q, day_q;
	logic [3:0] mon_q;
	logic [7:0] year_q;
	logic [2:0] wday_q;
	logic       fb_q;

	logic [AW-1:0] clr_q;
	logic          clr_busy_q;
	logic [CW-1:0] idx_q;
	logic [3:0]    nev_q;
	logic [7:0]    now_q;
	logic [11:0]   wacc_q;
	logic          rvalid_q;
	logic [SW-1:0] ridx_q;
	logic          scan_q;
	logic          pend_q;
	logic [SW-1:0] pslot_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;

	ccwt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_slots (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic take, out_take;
	assign take = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	assign in_stall = clr_busy_q || (state_q != ccwt_pkg::ST_IDLE);

	always_comb begin
		we = 1'b0;
		waddr = clr_q;
		wdata = 8'hFF;
		if (clr_busy_q) begin
			we = 1'b1;
		end else if (take && in.cmd == ccwt_pkg::CMD_SLOT && in.slot_weekday < 3'd7
				&& {2'b0, in.slot_index} < 5'(SLOTS_PER_DAY)) begin
			we = 1'b1;
			waddr = AW'(32'(in.slot_weekday) * SLOTS_PER_DAY + 32'(in.slot_index));
			wdata = in.slot_time;
		end
	end

	assign raddr = AW'(32'(wday_q) * SLOTS_PER_DAY + 32'(idx_q));

	// Tick arithmetic for the current state
	logic [5:0] sec_n, min_n;
	logic [4:0] hour_n, day_n;
	logic [3:0] mon_n;
	logic [7:0] year_n;
	logic [2:0] wday_n;
	logic       fb_n, roll_min, lastsun;
	always_comb begin
		sec_n = sec_q + 6'd1;
		min_n = min_q; hour_n = hour_q; day_n = day_q; mon_n = mon_q;
		year_n = year_q; wday_n = wday_q; fb_n = fb_q;
		roll_min = 1'b0;
		lastsun = 1'b0;
		if (sec_n >= 6'd60) begin
			sec_n = 6'd0;
			roll_min = 1'b1;
			min_n = min_q + 6'd1;
			if (min_n >= 6'd60) begin
				min_n = 6'd0;
				hour_n = hour_q + 5'd1;
				if (hour_n >= 5'd24) begin
					hour_n = 5'd0;
					if (day_q >= ccwt_pkg::month_days(mon_q, year_q)) begin
						day_n = 5'd1;
						mon_n = mon_q + 4'd1;
						if (mon_n >= 4'd13) begin
							mon_n = 4'd1;
							year_n = year_q + 8'd1;
						end
						if (mon_n == 4'd11) fb_n = 1'b0;
					end else begin
						day_n = day_q + 5'd1;
					end
					wday_n = (wday_q >= 3'd6) ? 3'd0 : wday_q + 3'd1;
				end
				lastsun = (day_n > 5'd24) && (wday_n == 3'd6);
				if (mon_n == 4'd3 && hour_n == 5'd2 && lastsun) hour_n = 5'd3;
				if (mon_n == 4'd10 && hour_n == 5'd3 && !fb_n && lastsun) begin
					hour_n = 5'd2;
					fb_n = 1'b1;
				end
			end
		end
	end

	logic [2:0] min_tens;
	always_comb begin
		if (min_n >= 6'd50) min_tens = 3'd5;
		else if (min_n >= 6'd40) min_tens = 3'd4;
		else if (min_n >= 6'd30) min_tens = 3'd3;
		else if (min_n >= 6'd20) min_tens = 3'd2;
		else if (min_n >= 6'd10) min_tens = 3'd1;
		else min_tens = 3'd0;
	end

	// Day count residue for the weekday: t = y + (y-1)/4 - (y-1)/100 + 5 + doy (4 + doy for year 0)
	logic [7:0]  ym1;
	logic [11:0] tsum;
	logic [5:0]  q4;
	logic [1:0]  q100;
	always_comb begin
		ym1 = year_q - 8'd1;
		q4 = ym1[7:2];
		q100 = (ym1 >= 8'd200) ? 2'd2 : ((ym1 >= 8'd100) ? 2'd1 : 2'd0);
		if (year_q == 8'd0)
			tsum = 12'(ccwt_pkg::month_base(mon_q, 1'b1)) + 12'(day_q) + 12'd4;
		else
			tsum = 12'(year_q) + 12'(q4) - 12'(q100) + 12'd1 + 12'd4
				+ 12'(ccwt_pkg::month_base(mon_q, year_q[1:0] == 2'd0)) + 12'(day_q);
	end

	logic scan_hit;
	assign scan_hit = rvalid_q && (rdata == now_q) && (nev_q < 4'(ccwt_pkg::RESULT_LIMIT));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ccwt_pkg::ST_IDLE: begin
				if (take) begin
					if (in.cmd == ccwt_pkg::CMD_SET && (in.field_select == ccwt_pkg::SEL_DAY
							|| in.field_select == ccwt_pkg::SEL_MONTH
							|| in.field_select == ccwt_pkg::SEL_YEAR))
						state_d = ccwt_pkg::ST_WDAY;
					else if (in.cmd == ccwt_pkg::CMD_TICK && roll_min
							&& (min_n == 6'd0 || min_n == 6'd10 || min_n == 6'd20
							|| min_n == 6'd30 || min_n == 6'd40 || min_n == 6'd50))
						state_d = ccwt_pkg::ST_SCAN;
					else
						state_d = ccwt_pkg::ST_DONE;
				end
			end
			ccwt_pkg::ST_WDAY: if (wacc_q < 12'd7) state_d = ccwt_pkg::ST_DONE;
			ccwt_pkg::ST_SCAN: begin
				if (scan_hit && pend_q) state_d = ccwt_pkg::ST_EMIT;
				else if (!scan_q && !rvalid_q) state_d = ccwt_pkg::ST_DONE;
			end
			ccwt_pkg::ST_EMIT: if (out_take) state_d = ccwt_pkg::ST_SCAN;
			ccwt_pkg::ST_DONE: if (out_take) state_d = ccwt_pkg::ST_IDLE;
			default: state_d = ccwt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccwt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold each event back until the next match or the end of the scan sets its last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= '0; min_q <= '0; hour_q <= '0; day_q <= 5'd1; mon_q <= 4'd1;
			year_q <= 8'd8; wday_q <= 3'd1; fb_q <= 1'b0;
			clr_q <= '0; clr_busy_q <= 1'b1;
			idx_q <= '0; nev_q <= '0; now_q <= '0; wacc_q <= '0;
			rvalid_q <= 1'b0; ridx_q <= '0; scan_q <= 1'b0;
			pend_q <= 1'b0; pslot_q <= '0;
			out_valid <= 1'b0; out <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(DEPTH - 1)) clr_busy_q <= 1'b0;
			end
			if (out_take) out_valid <= 1'b0;
			case (state_q)
				ccwt_pkg::ST_IDLE: begin
					if (take) begin
						idx_q <= '0; nev_q <= '0; rvalid_q <= 1'b0; pend_q <= 1'b0;
						case (in.cmd)
							ccwt_pkg::CMD_TICK: begin
								sec_q <= sec_n; min_q <= min_n; hour_q <= hour_n;
								day_q <= day_n; mon_q <= mon_n; year_q <= year_n;
								wday_q <= wday_n; fb_q <= fb_n;
								now_q <= 8'(hour_n * 10) + 8'(min_tens);
								scan_q <= 1'b1;
							end
							ccwt_pkg::CMD_SET: begin
								case (in.field_select)
									ccwt_pkg::SEL_SEC: if (in.set_value < 8'd60) sec_q <= in.set_value[5:0];
									ccwt_pkg::SEL_MIN: if (in.set_value < 8'd60) min_q <= in.set_value[5:0];
									ccwt_pkg::SEL_HOUR: if (in.set_value < 8'd24) hour_q <= in.set_value[4:0];
									ccwt_pkg::SEL_DAY:
										if (in.set_value >= 8'd1 && in.set_value <= 8'd31) day_q <= in.set_value[4:0];
									ccwt_pkg::SEL_MONTH:
										if (in.set_value >= 8'd1 && in.set_value <= 8'd12) mon_q <= in.set_value[3:0];
									ccwt_pkg::SEL_YEAR: year_q <= in.set_value;
									default: ;
								endcase
								wacc_q <= 12'hFFF;
							end
							default: ;
						endcase
					end
				end
				ccwt_pkg::ST_WDAY: begin
					// Reduce the day count mod 7, one subtract of a power-of-two multiple a cycle
					if (wacc_q == 12'hFFF) wacc_q <= tsum;
					else if (wacc_q >= 12'd1792) wacc_q <= wacc_q - 12'd1792;
					else if (wacc_q >= 12'd224) wacc_q <= wacc_q - 12'd224;
					else if (wacc_q >= 12'd28) wacc_q <= wacc_q - 12'd28;
					else if (wacc_q >= 12'd7) wacc_q <= wacc_q - 12'd7;
					else wday_q <= wacc_q[2:0];
				end
				ccwt_pkg::ST_SCAN: begin
					if (scan_hit && pend_q) begin
						out_valid <= 1'b1;
						out <= '{second_now: sec_q, minute_now: min_q, hour_now: hour_q,
							day_now: day_q, month_now: mon_q, year_now: year_q,
							weekday_now: wday_q, dst_done_now: fb_q, event_valid: 1'b1,
							event_slot: 3'(pslot_q), last: 1'b0};
						pslot_q <= ridx_q;
						nev_q <= nev_q + 4'd1;
						rvalid_q <= 1'b0;
					end else begin
						rvalid_q <= scan_q;
						ridx_q <= idx_q[SW-1:0];
						if (scan_q) begin
							if (idx_q == CW'(SLOTS_PER_DAY - 1)) scan_q <= 1'b0;
							idx_q <= idx_q + CW'(1);
						end
						if (scan_hit) begin
							pend_q <= 1'b1;
							pslot_q <= ridx_q;
							nev_q <= nev_q + 4'd1;
						end
						if (!scan_q && !rvalid_q && pend_q) begin
							out_valid <= 1'b1;
							out <= '{second_now: sec_q, minute_now: min_q, hour_now: hour_q,
								day_now: day_q, month_now: mon_q, year_now: year_q,
								weekday_now: wday_q, dst_done_now: fb_q, event_valid: 1'b1,
								event_slot: 3'(pslot_q), last: 1'b1};
						end
					end
				end
				ccwt_pkg::ST_EMIT: ;
				ccwt_pkg::ST_DONE: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						out <= '{second_now: sec_q, minute_now: min_q, hour_now: hour_q,
							day_now: day_q, month_now: mon_q, year_now: year_q,
							weekday_now: wday_q, dst_done_now: fb_q, event_valid: 1'b0,
							event_slot: 3'd0, last: 1'b1};
					end
				end
				default: ;
			endcase
		end
	end
endmodule

>>> hdl/ccwt_ram.sv
// Generic single-port write, registered-read RAM
module ccwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 56
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
